### design/wavelength_to_rgb_gamma_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wavelength to RGB block
// Short forms for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WAVELENGTH_TO_RGB_GAMMA_TOP_MACROS_SVH
`define WAVELENGTH_TO_RGB_GAMMA_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define WTRGB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define WTRGB_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/wtrgb_pkg.sv
// ----------------------------------------------------------------------------
// wtrgb_pkg
// Widths, constants, the exp2 table and shared types of the wavelength block.
// ----------------------------------------------------------------------------
package wtrgb_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int INTENSITY_BITS = 16;
  localparam int LOG_BITS       = 30;

  // field widths
  localparam int WL_W    = 10;
  localparam int GAMMA_W = 10;
  localparam int MAXI_W  = 16;
  localparam int CH_W    = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_GAMMA = 1'b0;
  localparam logic CFG_IDX_MAXI  = 1'b1;
  localparam logic [GAMMA_W-1:0] GAMMA_RST = 10'd205;
  localparam logic [MAXI_W-1:0]  MAXI_RST  = 16'd255;

  // segment boundaries in nm
  localparam int WL_MIN     = 380;
  localparam int WL_G_RISE  = 440;
  localparam int WL_B_FALL  = 490;
  localparam int WL_R_RISE  = 510;
  localparam int WL_G_FALL  = 580;
  localparam int WL_R_FULL  = 645;
  localparam int WL_FADE_LO = 420;
  localparam int WL_FADE_HI = 700;
  localparam int WL_MAX     = 780;

  // segment spans
  localparam int SPAN_R_FALL = 60;
  localparam int SPAN_G_RISE = 50;
  localparam int SPAN_B_FALL = 20;
  localparam int SPAN_R_RISE = 70;
  localparam int SPAN_G_FALL = 65;

  // edge fade: 0.3 + 0.7*d/40 = (120 + 7d)/400, 0.3 + 0.7*d/80 = (240 + 7d)/800
  localparam int FADE_LO_BASE = 120;
  localparam int FADE_LO_DEN  = 400;
  localparam int FADE_HI_BASE = 240;
  localparam int FADE_HI_DEN  = 800;
  localparam int FADE_SLOPE   = 7;

  // datapath widths
  localparam int CN_W   = 7;
  localparam int FN_W   = 10;
  localparam int CF_W   = CN_W + FN_W;
  localparam int DEN_W  = 17;
  localparam int NUM_W  = FRAC_BITS + 18;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int P_W    = $clog2(FRAC_BITS + 1);
  localparam int M_W    = LOG_BITS + 1;
  localparam int SQ_W   = LOG_BITS + 2;
  localparam int T_W    = LOG_BITS + P_W;
  localparam int GP_W   = T_W + GAMMA_W;
  localparam int Y_W    = T_W + 3;
  localparam int N_W    = Y_W - LOG_BITS;
  localparam int R_W    = LOG_BITS + 2;
  localparam int A_W    = LOG_BITS + 1;
  localparam int PA_W   = 2 * R_W;
  localparam int PROD_W = MAXI_W + R_W;
  localparam int SCL_W  = 64;

  localparam int GAMMA_FRAC    = 8;
  localparam int GAMMA_HALF    = 128;
  localparam int MAX_EXP_SHIFT = 32;

  // stage counts
  localparam int CHAN_LAT  = Q_W + 2 * LOG_BITS + 5;
  localparam int TOP_DEPTH = CHAN_LAT + 2;

  typedef struct packed {
    logic             zero;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den2;
  } chan_req_t;

  typedef logic [LOG_BITS:0][A_W-1:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bw;
    res = '0;
    rem = v;
    bw  = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  // A[i] = 2^(-2^-i) in Q0.31, by repeated square roots from 0.5
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    tab[0] = A_W'(1) << LOG_BITS;
    for (int i = 1; i <= LOG_BITS; i++) begin
      tab[i] = A_W'(isqrt64(64'(tab[i-1]) << (LOG_BITS + 1)));
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

### design/wtrgb_chan.sv
// ----------------------------------------------------------------------------
// wtrgb_chan
// One color channel: divide, log2, gamma multiply, exp2 and scale, pipelined.
// ----------------------------------------------------------------------------
module wtrgb_chan (
  input  logic                             clk,
  input  logic                             en,
  input  logic [wtrgb_pkg::GAMMA_W-1:0]    gamma,
  input  logic [wtrgb_pkg::MAXI_W-1:0]     max_intensity,
  input  wtrgb_pkg::chan_req_t             req,
  output logic [wtrgb_pkg::CH_W-1:0]       value
);

  typedef struct packed {
    logic                        zero;
    logic [wtrgb_pkg::NUM_W-1:0] num;
    logic [wtrgb_pkg::DEN_W-1:0] d;
    logic [wtrgb_pkg::DEN_W-1:0] rem;
    logic [wtrgb_pkg::Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    logic                           zero;
    logic [wtrgb_pkg::P_W-1:0]      p;
    logic [wtrgb_pkg::M_W-1:0]      m;
    logic [wtrgb_pkg::LOG_BITS-1:0] bits;
  } log_t;

  typedef struct packed {
    logic                           zero;
    logic [wtrgb_pkg::N_W-1:0]      n;
    logic [wtrgb_pkg::LOG_BITS-1:0] f;
    logic [wtrgb_pkg::R_W-1:0]      r;
  } exp_t;

  typedef struct packed {
    logic                       zero;
    logic [wtrgb_pkg::T_W-1:0]  t;
  } t_t;

  typedef struct packed {
    logic                         zero;
    logic [wtrgb_pkg::N_W-1:0]    n;
    logic [wtrgb_pkg::PROD_W-1:0] pr;
  } prod_t;

  // ---- restoring division, one quotient bit per stage ----
  div_t div_init;
  div_t div_r [wtrgb_pkg::Q_W];

  always_comb begin
    div_init.zero = req.zero;
    div_init.num  = req.num;
    div_init.d    = req.den2;
    div_init.rem  = wtrgb_pkg::DEN_W'(req.num >> wtrgb_pkg::Q_W);
    div_init.q    = '0;
  end

  for (genvar k = 0; k < wtrgb_pkg::Q_W; k++) begin : g_div
    div_t                        prev;
    div_t                        div_nxt;
    logic [wtrgb_pkg::DEN_W:0]   tmp;
    logic                        ge;
    if (k == 0) begin : g_first
      assign prev = div_init;
    end else begin : g_rest
      assign prev = div_r[k-1];
    end
    always_comb begin
      tmp             = {prev.rem, prev.num[wtrgb_pkg::Q_W-1-k]};
      ge              = (tmp >= {1'b0, prev.d});
      div_nxt         = prev;
      div_nxt.rem     = ge ? wtrgb_pkg::DEN_W'(tmp - {1'b0, prev.d})
                           : wtrgb_pkg::DEN_W'(tmp);
      div_nxt.q       = {prev.q[wtrgb_pkg::Q_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k] <= div_nxt;
      end
    end
  end

  // ---- clamp and normalize to Q1.30 ----
  log_t                      norm_nxt;
  log_t                      norm_r;
  logic [wtrgb_pkg::Q_W-1:0] xq;

  always_comb begin
    xq = div_r[wtrgb_pkg::Q_W-1].q;
    if (xq > (wtrgb_pkg::Q_W'(1) << wtrgb_pkg::FRAC_BITS)) begin
      xq = wtrgb_pkg::Q_W'(1) << wtrgb_pkg::FRAC_BITS;
    end
    norm_nxt.p = '0;
    for (int b = 0; b < wtrgb_pkg::Q_W; b++) begin
      if (xq[b]) begin
        norm_nxt.p = wtrgb_pkg::P_W'(b);
      end
    end
    norm_nxt.zero = div_r[wtrgb_pkg::Q_W-1].zero | (xq == '0);
    norm_nxt.m    = wtrgb_pkg::M_W'(xq) << (wtrgb_pkg::LOG_BITS - int'(norm_nxt.p));
    norm_nxt.bits = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= norm_nxt;
    end
  end

  // ---- log2 by repeated squaring, one fraction bit per stage ----
  log_t log_r [wtrgb_pkg::LOG_BITS];

  for (genvar k = 0; k < wtrgb_pkg::LOG_BITS; k++) begin : g_log
    log_t                          prev;
    log_t                          log_nxt;
    logic [2*wtrgb_pkg::M_W-1:0]   sq;
    logic [wtrgb_pkg::SQ_W-1:0]    m2;
    if (k == 0) begin : g_first
      assign prev = norm_r;
    end else begin : g_rest
      assign prev = log_r[k-1];
    end
    always_comb begin
      sq      = (2*wtrgb_pkg::M_W)'(prev.m) * (2*wtrgb_pkg::M_W)'(prev.m);
      m2      = wtrgb_pkg::SQ_W'(sq >> wtrgb_pkg::LOG_BITS);
      log_nxt = prev;
      log_nxt.bits = {prev.bits[wtrgb_pkg::LOG_BITS-2:0], m2[wtrgb_pkg::SQ_W-1]};
      log_nxt.m    = m2[wtrgb_pkg::SQ_W-1] ? wtrgb_pkg::M_W'(m2 >> 1)
                                           : wtrgb_pkg::M_W'(m2);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        log_r[k] <= log_nxt;
      end
    end
  end

  // ---- t = -log2(x) ----
  t_t t_nxt;
  t_t t_r;

  always_comb begin
    t_nxt.zero = log_r[wtrgb_pkg::LOG_BITS-1].zero;
    t_nxt.t    = ((wtrgb_pkg::T_W'(wtrgb_pkg::FRAC_BITS)
                   - wtrgb_pkg::T_W'(log_r[wtrgb_pkg::LOG_BITS-1].p)) << wtrgb_pkg::LOG_BITS)
                 - wtrgb_pkg::T_W'(log_r[wtrgb_pkg::LOG_BITS-1].bits);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  // ---- y = t * gamma, split into shift n and fraction f ----
  exp_t                       y_nxt;
  exp_t                       y_r;
  logic [wtrgb_pkg::GP_W-1:0] gp;
  logic [wtrgb_pkg::Y_W-1:0]  y;

  always_comb begin
    gp         = wtrgb_pkg::GP_W'(t_r.t) * wtrgb_pkg::GP_W'(gamma);
    y          = wtrgb_pkg::Y_W'((gp + wtrgb_pkg::GP_W'(wtrgb_pkg::GAMMA_HALF))
                                 >> wtrgb_pkg::GAMMA_FRAC);
    y_nxt.n    = y[wtrgb_pkg::Y_W-1:wtrgb_pkg::LOG_BITS];
    y_nxt.f    = y[wtrgb_pkg::LOG_BITS-1:0];
    y_nxt.zero = t_r.zero | (y_nxt.n > wtrgb_pkg::N_W'(wtrgb_pkg::MAX_EXP_SHIFT));
    y_nxt.r    = wtrgb_pkg::R_W'(1) << (wtrgb_pkg::LOG_BITS + 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  // ---- exp2 of the fraction, one table factor per stage ----
  exp_t exp_r [wtrgb_pkg::LOG_BITS];

  for (genvar k = 0; k < wtrgb_pkg::LOG_BITS; k++) begin : g_exp
    exp_t                        prev;
    exp_t                        exp_nxt;
    logic [wtrgb_pkg::PA_W-1:0]  pa;
    if (k == 0) begin : g_first
      assign prev = y_r;
    end else begin : g_rest
      assign prev = exp_r[k-1];
    end
    always_comb begin
      pa      = wtrgb_pkg::PA_W'(prev.r) * wtrgb_pkg::PA_W'(wtrgb_pkg::EXP_TAB[k+1])
                + (wtrgb_pkg::PA_W'(1) << wtrgb_pkg::LOG_BITS);
      exp_nxt = prev;
      if (prev.f[wtrgb_pkg::LOG_BITS-1-k]) begin
        exp_nxt.r = wtrgb_pkg::R_W'(pa >> (wtrgb_pkg::LOG_BITS + 1));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        exp_r[k] <= exp_nxt;
      end
    end
  end

  // ---- scale by full-scale intensity ----
  prod_t prod_nxt;
  prod_t prod_r;

  always_comb begin
    prod_nxt.zero = exp_r[wtrgb_pkg::LOG_BITS-1].zero;
    prod_nxt.n    = exp_r[wtrgb_pkg::LOG_BITS-1].n;
    prod_nxt.pr   = wtrgb_pkg::PROD_W'(max_intensity)
                    * wtrgb_pkg::PROD_W'(exp_r[wtrgb_pkg::LOG_BITS-1].r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // ---- round, shift down by 31+n, saturate ----
  logic [wtrgb_pkg::SCL_W-1:0] sum;
  logic [wtrgb_pkg::SCL_W-1:0] shifted;
  logic [wtrgb_pkg::CH_W-1:0]  value_nxt;
  logic [wtrgb_pkg::CH_W-1:0]  value_r;

  always_comb begin
    sum     = wtrgb_pkg::SCL_W'(prod_r.pr)
              + (wtrgb_pkg::SCL_W'(1) << (wtrgb_pkg::LOG_BITS + int'(prod_r.n)));
    shifted = sum >> (wtrgb_pkg::LOG_BITS + 1 + int'(prod_r.n));
    if (prod_r.zero) begin
      value_nxt = '0;
    end else if (shifted > ((wtrgb_pkg::SCL_W'(1) << wtrgb_pkg::INTENSITY_BITS) - 1)) begin
      value_nxt = wtrgb_pkg::CH_W'((wtrgb_pkg::SCL_W'(1) << wtrgb_pkg::INTENSITY_BITS) - 1);
    end else begin
      value_nxt = wtrgb_pkg::CH_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

### design/wavelength_to_rgb_gamma_top.sv
// ----------------------------------------------------------------------------
// wavelength_to_rgb_gamma_top
// Wavelength in nm to gamma-corrected red, green and blue intensities.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one wavelength per transaction, in_tdata[9:0] in whole nm.
//   out_* : one result per input transaction, same order. out_tdata holds
//           red, green, blue (16 bits each); out_tuser is the in-range flag.
//   cfg_* : register 0 (byte 0) gamma, Q2.8; register 1 (byte 4)
//           max_intensity. Write only while no transaction is in flight.
// The pipeline from input to output has TOP_DEPTH stages (input stage,
// segment decode, 17 divider stages, normalize, 30 log2 stages, t, gamma
// multiply, 30 exp2 stages, scale, round). One transaction per cycle is
// accepted while the output moves; the long pipeline of per-bit log2/exp2
// multiplier stages sets the latency, not the rate.
// Reset clears all valid bits and loads gamma=205, max_intensity=255.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops in the same cycle; nothing is lost or repeated.
// Wavelengths outside 380..780 nm give zero colors and in-range low.
// ----------------------------------------------------------------------------
module wavelength_to_rgb_gamma_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] wavelength
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] red, [31:16] green, [47:32] blue
  output logic [0:0]  out_tuser,  // [0] in_range
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wtrgb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wtrgb_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wtrgb_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  // ---- configuration registers ----
  logic [wtrgb_pkg::GAMMA_W-1:0] gamma_r;
  logic [wtrgb_pkg::MAXI_W-1:0]  maxi_r;
  logic                          cfg_wr;
  logic                          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= wtrgb_pkg::GAMMA_RST;
      maxi_r  <= wtrgb_pkg::MAXI_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == wtrgb_pkg::CFG_IDX_GAMMA) begin
        gamma_r <= cfg_pwdata[wtrgb_pkg::GAMMA_W-1:0];
      end else begin
        maxi_r <= cfg_pwdata[wtrgb_pkg::MAXI_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_idx == wtrgb_pkg::CFG_IDX_MAXI) begin
      cfg_prdata = wtrgb_pkg::CFG_DATA_W'(maxi_r);
    end else begin
      cfg_prdata = wtrgb_pkg::CFG_DATA_W'(gamma_r);
    end
  end

  // ---- pipeline control: global hold while output waits ----
  logic                            en;
  logic [wtrgb_pkg::TOP_DEPTH-1:0] vld_r;
  logic [wtrgb_pkg::TOP_DEPTH-1:0] rng_r;
  logic                            rng_in;

  assign en        = ~vld_r[wtrgb_pkg::TOP_DEPTH-1] | out_tready;
  assign in_tready = en;
  assign rng_in    = (in_tdata[wtrgb_pkg::WL_W-1:0] >= wtrgb_pkg::WL_W'(wtrgb_pkg::WL_MIN)) &&
                     (in_tdata[wtrgb_pkg::WL_W-1:0] <= wtrgb_pkg::WL_W'(wtrgb_pkg::WL_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[wtrgb_pkg::TOP_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng_r <= {rng_r[wtrgb_pkg::TOP_DEPTH-2:0], rng_in};
    end
  end

  // ---- input register ----
  logic [wtrgb_pkg::WL_W-1:0] wl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wl_r <= in_tdata[wtrgb_pkg::WL_W-1:0];
    end
  end

  // ---- segment decode: channel and fade fractions as ratios ----
  logic [wtrgb_pkg::CN_W-1:0] rn, rd, gn, gd, bn, bd;
  logic [wtrgb_pkg::FN_W-1:0] fn, fd;
  wtrgb_pkg::chan_req_t       req_nxt [3];
  wtrgb_pkg::chan_req_t       req_r   [3];

  always_comb begin
    rd = wtrgb_pkg::CN_W'(1);
    gd = wtrgb_pkg::CN_W'(1);
    bd = wtrgb_pkg::CN_W'(1);
    if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_G_RISE)) begin
      rn = wtrgb_pkg::CN_W'(wtrgb_pkg::WL_G_RISE - int'(wl_r));
      rd = wtrgb_pkg::CN_W'(wtrgb_pkg::SPAN_R_FALL);
      gn = '0;
      bn = wtrgb_pkg::CN_W'(1);
    end else if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_B_FALL)) begin
      rn = '0;
      gn = wtrgb_pkg::CN_W'(int'(wl_r) - wtrgb_pkg::WL_G_RISE);
      gd = wtrgb_pkg::CN_W'(wtrgb_pkg::SPAN_G_RISE);
      bn = wtrgb_pkg::CN_W'(1);
    end else if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_R_RISE)) begin
      rn = '0;
      gn = wtrgb_pkg::CN_W'(1);
      bn = wtrgb_pkg::CN_W'(wtrgb_pkg::WL_R_RISE - int'(wl_r));
      bd = wtrgb_pkg::CN_W'(wtrgb_pkg::SPAN_B_FALL);
    end else if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_G_FALL)) begin
      rn = wtrgb_pkg::CN_W'(int'(wl_r) - wtrgb_pkg::WL_R_RISE);
      rd = wtrgb_pkg::CN_W'(wtrgb_pkg::SPAN_R_RISE);
      gn = wtrgb_pkg::CN_W'(1);
      bn = '0;
    end else if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_R_FULL)) begin
      rn = wtrgb_pkg::CN_W'(1);
      gn = wtrgb_pkg::CN_W'(wtrgb_pkg::WL_R_FULL - int'(wl_r));
      gd = wtrgb_pkg::CN_W'(wtrgb_pkg::SPAN_G_FALL);
      bn = '0;
    end else begin
      rn = wtrgb_pkg::CN_W'(1);
      gn = '0;
      bn = '0;
    end

    // edge fade toward the ends of the visible range
    if (wl_r < wtrgb_pkg::WL_W'(wtrgb_pkg::WL_FADE_LO)) begin
      fn = wtrgb_pkg::FN_W'(wtrgb_pkg::FADE_LO_BASE
                            + wtrgb_pkg::FADE_SLOPE * (int'(wl_r) - wtrgb_pkg::WL_MIN));
      fd = wtrgb_pkg::FN_W'(wtrgb_pkg::FADE_LO_DEN);
    end else if (wl_r <= wtrgb_pkg::WL_W'(wtrgb_pkg::WL_FADE_HI)) begin
      fn = wtrgb_pkg::FN_W'(1);
      fd = wtrgb_pkg::FN_W'(1);
    end else begin
      fn = wtrgb_pkg::FN_W'(wtrgb_pkg::FADE_HI_BASE
                            + wtrgb_pkg::FADE_SLOPE * (wtrgb_pkg::WL_MAX - int'(wl_r)));
      fd = wtrgb_pkg::FN_W'(wtrgb_pkg::FADE_HI_DEN);
    end
  end

  // numerator 2*cn*fn*2^FRAC + den over divisor 2*den rounds to nearest
  function automatic wtrgb_pkg::chan_req_t mk_req(
    input logic [wtrgb_pkg::CN_W-1:0] cn,
    input logic [wtrgb_pkg::CN_W-1:0] cd,
    input logic [wtrgb_pkg::FN_W-1:0] fnum,
    input logic [wtrgb_pkg::FN_W-1:0] fden,
    input logic                       in_rng
  );
    wtrgb_pkg::chan_req_t       req;
    logic [wtrgb_pkg::CF_W-1:0] cf;
    logic [wtrgb_pkg::DEN_W-1:0] den;
    cf       = wtrgb_pkg::CF_W'(cn) * wtrgb_pkg::CF_W'(fnum);
    den      = wtrgb_pkg::DEN_W'(cd) * wtrgb_pkg::DEN_W'(fden);
    req.zero = ~in_rng | (cn == '0);
    req.num  = (wtrgb_pkg::NUM_W'(cf) << (wtrgb_pkg::FRAC_BITS + 1)) + wtrgb_pkg::NUM_W'(den);
    req.den2 = den << 1;
    return req;
  endfunction

  always_comb begin
    req_nxt[0] = mk_req(rn, rd, fn, fd, rng_r[0]);
    req_nxt[1] = mk_req(gn, gd, fn, fd, rng_r[0]);
    req_nxt[2] = mk_req(bn, bd, fn, fd, rng_r[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= req_nxt;
    end
  end

  // ---- per-channel pipelines ----
  logic [wtrgb_pkg::CH_W-1:0] chan_val [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    wtrgb_chan u_chan (
      .clk           (clk),
      .en            (en),
      .gamma         (gamma_r),
      .max_intensity (maxi_r),
      .req           (req_r[c]),
      .value         (chan_val[c])
    );
  end

  assign out_tvalid = vld_r[wtrgb_pkg::TOP_DEPTH-1];
  assign out_tdata  = {chan_val[2], chan_val[1], chan_val[0]};
  assign out_tuser  = rng_r[wtrgb_pkg::TOP_DEPTH-1];

endmodule

### design/wtrgb_chk.sv
// ----------------------------------------------------------------------------
// wtrgb_chk
// Port-level checks on the wavelength to RGB block, bound to the top level.
// ----------------------------------------------------------------------------
`include "wavelength_to_rgb_gamma_top_macros.svh"

module wtrgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // held result must not change under backpressure
  `WTRGB_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // out-of-range wavelength gives black
  `WTRGB_ASSERT(a_range_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == 48'd0, "nonzero color for out-of-range wavelength")

  // with no pending result the input is always open
  `WTRGB_ASSERT(a_ready_free, clk, rst_n, !out_tvalid |-> in_tready, "input blocked with empty output")

  // reset empties the pipeline
  `WTRGB_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind wavelength_to_rgb_gamma_top wtrgb_chk u_wtrgb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
